// ===== rtl/core/mld_pkg.sv =====
// Types and constants shared by the marker/length deframer.
package mld_pkg;

  // Framing constants
  localparam logic [7:0] MarkerByte = 8'hFF;
  localparam int unsigned MarkerLen = 4;
  localparam int unsigned LenBytes = 8;

  // Result queue geometry
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned PtrW = 2;
  localparam int unsigned CountW = 3;

  typedef enum logic [1:0] {
    PhHunt = 2'd0,
    PhLen  = 2'd1,
    PhPay  = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    KindPayload = 2'd0,
    KindEmpty   = 2'd1,
    KindResync  = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  payload_byte;
    logic        end_of_packet;
    logic [31:0] dropped_bytes;
    logic [63:0] next_length;
    logic        last;
  } result_t;

endpackage

// ===== rtl/core/marker_length_deframer.sv =====
// Marker/length deframer: splits a byte stream into length-prefixed packets.

// Takes one byte per clock cycle on the input channel. Each frame is four 0xFF
// marker bytes, an 8-byte big-endian length and the payload. While hunting,
// bytes that do not form the marker are counted as dropped (saturating at
// 2^32-1), and the header that ends a hunt after drops gives a resync report.
// Each accepted byte updates the framing state in the same cycle and writes
// zero, one or two results into a four-entry result queue, which drives the
// output channel one result per cycle while the receiver is ready. The input is
// ready whenever at least two queue entries are free, so with the output taken
// every cycle a byte is accepted every cycle; a zero-length header after drops
// writes two results.
module marker_length_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  payload_byte_o,
  output logic        end_of_packet_o,
  output logic [31:0] dropped_bytes_o,
  output logic [63:0] next_length_o,
  output logic        last_o
);

  localparam int unsigned PtrW = mld_pkg::PtrW;
  localparam int unsigned CountW = mld_pkg::CountW;

  mld_pkg::phase_e phase_q, phase_d;
  logic [2:0]  marker_run_q, marker_run_d;
  logic [3:0]  length_index_q, length_index_d;
  logic [63:0] length_accum_q, length_accum_d;
  logic [63:0] payload_remaining_q, payload_remaining_d;
  logic [31:0] drop_count_q, drop_count_d;

  mld_pkg::result_t queue_q [mld_pkg::QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CountW-1:0] count_q;

  mld_pkg::result_t res0, res1;
  logic [1:0]  push_cnt;
  logic        in_fire, out_fire;
  logic [2:0]  run_inc;
  logic [32:0] drop_sum;
  logic [63:0] accum_shift;
  logic [3:0]  index_inc;
  logic [63:0] remaining_dec;

  assign in_ready_o  = (count_q <= CountW'(mld_pkg::QueueDepth - 2));
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = (count_q != '0);
  assign out_fire    = out_valid_o && out_ready_i;

  assign run_inc       = marker_run_q + 3'd1;
  assign drop_sum      = {1'b0, drop_count_q} + {30'd0, run_inc};
  assign accum_shift   = {length_accum_q[55:0], data_byte_i};
  assign index_inc     = length_index_q + 4'd1;
  assign remaining_dec = payload_remaining_q - 64'd1;

  // Advance the framing state for one byte and form its results
  always_comb begin
    phase_d             = phase_q;
    marker_run_d        = marker_run_q;
    length_index_d      = length_index_q;
    length_accum_d      = length_accum_q;
    payload_remaining_d = payload_remaining_q;
    drop_count_d        = drop_count_q;
    res0                = '0;
    res1                = '0;
    push_cnt            = 2'd0;
    if (in_fire) begin
      unique case (phase_q)
        mld_pkg::PhLen: begin
          length_accum_d = accum_shift;
          length_index_d = index_inc;
          if (index_inc >= 4'(mld_pkg::LenBytes)) begin
            length_index_d = '0;
            length_accum_d = '0;
            marker_run_d   = '0;
            drop_count_d   = '0;
            if (drop_count_q != '0) begin
              res0.kind          = mld_pkg::KindResync;
              res0.dropped_bytes = drop_count_q;
              res0.next_length   = accum_shift;
              res0.last          = (accum_shift != '0);
              push_cnt           = 2'd1;
            end
            if (accum_shift == '0) begin
              phase_d = mld_pkg::PhHunt;
              if (drop_count_q != '0) begin
                res1.kind          = mld_pkg::KindEmpty;
                res1.end_of_packet = 1'b1;
                res1.last          = 1'b1;
                push_cnt           = 2'd2;
              end else begin
                res0.kind          = mld_pkg::KindEmpty;
                res0.end_of_packet = 1'b1;
                res0.last          = 1'b1;
                push_cnt           = 2'd1;
              end
            end else begin
              payload_remaining_d = accum_shift;
              phase_d             = mld_pkg::PhPay;
            end
          end
        end
        mld_pkg::PhPay: begin
          payload_remaining_d = remaining_dec;
          res0.kind           = mld_pkg::KindPayload;
          res0.payload_byte   = data_byte_i;
          res0.end_of_packet  = (remaining_dec == '0);
          res0.last           = 1'b1;
          push_cnt            = 2'd1;
          if (remaining_dec == '0) begin
            phase_d      = mld_pkg::PhHunt;
            marker_run_d = '0;
          end
        end
        default: begin
          // Hunt, and treat the unused phase code as hunting
          phase_d = mld_pkg::PhHunt;
          if (data_byte_i == mld_pkg::MarkerByte) begin
            marker_run_d = run_inc;
            if (run_inc >= 3'(mld_pkg::MarkerLen)) begin
              marker_run_d   = '0;
              length_index_d = '0;
              length_accum_d = '0;
              phase_d        = mld_pkg::PhLen;
            end
          end else begin
            drop_count_d = drop_sum[32] ? 32'hFFFF_FFFF : drop_sum[31:0];
            marker_run_d = '0;
          end
        end
      endcase
    end
  end

  // Framing state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q             <= mld_pkg::PhHunt;
      marker_run_q        <= '0;
      length_index_q      <= '0;
      length_accum_q      <= '0;
      payload_remaining_q <= '0;
      drop_count_q        <= '0;
    end else begin
      phase_q             <= phase_d;
      marker_run_q        <= marker_run_d;
      length_index_q      <= length_index_d;
      length_accum_q      <= length_accum_d;
      payload_remaining_q <= payload_remaining_d;
      drop_count_q        <= drop_count_d;
    end
  end

  // Queue pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PtrW'(push_cnt);
      rd_ptr_q <= rd_ptr_q + PtrW'(out_fire);
      count_q  <= count_q + CountW'(push_cnt) - CountW'(out_fire);
    end
  end

  // Write up to two results per transaction into the queue
  always_ff @(posedge clk_i) begin
    if (push_cnt != 2'd0) begin
      queue_q[wr_ptr_q] <= res0;
    end
    if (push_cnt == 2'd2) begin
      queue_q[wr_ptr_q + PtrW'(1)] <= res1;
    end
  end

  // Drive the output from the queue head
  assign kind_o          = queue_q[rd_ptr_q].kind;
  assign payload_byte_o  = queue_q[rd_ptr_q].payload_byte;
  assign end_of_packet_o = queue_q[rd_ptr_q].end_of_packet;
  assign dropped_bytes_o = queue_q[rd_ptr_q].dropped_bytes;
  assign next_length_o   = queue_q[rd_ptr_q].next_length;
  assign last_o          = queue_q[rd_ptr_q].last;

  // Queue never overfills
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(mld_pkg::QueueDepth))
    else $error("result queue overflow");

  // A payload phase always has bytes still due
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == mld_pkg::PhPay) |-> (payload_remaining_q != '0))
    else $error("payload phase with nothing remaining");

  // The marker run is cleared whenever the length is being assembled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == mld_pkg::PhLen) |-> (marker_run_q == '0))
    else $error("marker run left over in length phase");

  // A resync report always carries a nonzero drop count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && kind_o == mld_pkg::KindResync) |-> (dropped_bytes_o != '0))
    else $error("resync report without dropped bytes");

endmodule

// ===== verif/tb_marker_length_deframer.sv =====
// Self-checking testbench for the marker/length deframer with scoreboard and stimulus.
`timescale 1ns / 100ps

module tb_marker_length_deframer;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned ResetCycles = 12;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned HoldOffCycles = 150;
  localparam int unsigned RandomBytes = 920;

  // Predict deframed results and compare them with what the block emits
  class deframe_scoreboard;
    mld_pkg::phase_e  phase;
    logic [2:0]       marker_run;
    logic [3:0]       len_count;
    logic [63:0]      len_acc;
    logic [63:0]      payload_left;
    logic [31:0]      drop_total;
    mld_pkg::result_t pending_results[$];
    int unsigned      errors;

    function new();
      phase        = mld_pkg::PhHunt;
      marker_run   = '0;
      len_count    = '0;
      len_acc      = '0;
      payload_left = '0;
      drop_total   = '0;
      errors       = 0;
    endfunction

    function mld_pkg::result_t make_result(mld_pkg::kind_e kind, logic [7:0] pb, logic eop,
                                           logic [31:0] dropped, logic [63:0] nlen);
      mld_pkg::result_t r;
      r.kind          = kind;
      r.payload_byte  = pb;
      r.end_of_packet = eop;
      r.dropped_bytes = dropped;
      r.next_length   = nlen;
      r.last          = 1'b0;
      return r;
    endfunction

    // Advance the framing state by one accepted byte and queue its results
    function void note_byte(logic [7:0] b);
      mld_pkg::result_t step_results[$];
      logic [31:0]      add;
      logic             eop;
      case (phase)
        mld_pkg::PhLen: begin
          len_acc   = {len_acc[55:0], b};
          len_count = len_count + 1'b1;
          if (len_count >= mld_pkg::LenBytes) begin
            if (drop_total != 0) begin
              step_results = {step_results,
                              make_result(mld_pkg::KindResync, 8'h00, 1'b0,
                                          drop_total, len_acc)};
              drop_total = '0;
            end
            if (len_acc == 0) begin
              step_results = {step_results,
                              make_result(mld_pkg::KindEmpty, 8'h00, 1'b1, '0, '0)};
              phase = mld_pkg::PhHunt;
            end else begin
              payload_left = len_acc;
              phase = mld_pkg::PhPay;
            end
            len_count  = '0;
            len_acc    = '0;
            marker_run = '0;
          end
        end
        mld_pkg::PhPay: begin
          payload_left = payload_left - 64'd1;
          eop = (payload_left == 0);
          step_results = {step_results,
                          make_result(mld_pkg::KindPayload, b, eop, '0, '0)};
          if (eop) begin
            phase = mld_pkg::PhHunt;
            marker_run = '0;
          end
        end
        default: begin
          phase = mld_pkg::PhHunt;
          if (b == mld_pkg::MarkerByte) begin
            marker_run = marker_run + 1'b1;
            if (marker_run >= mld_pkg::MarkerLen) begin
              marker_run = '0;
              len_count  = '0;
              len_acc    = '0;
              phase      = mld_pkg::PhLen;
            end
          end else begin
            // a broken run drops the marker bytes seen so far plus this one
            add = 32'(marker_run) + 32'd1;
            if (drop_total > 32'hFFFF_FFFF - add) drop_total = 32'hFFFF_FFFF;
            else drop_total = drop_total + add;
            marker_run = '0;
          end
        end
      endcase
      if (step_results.size() > 0) step_results[step_results.size() - 1].last = 1'b1;
      foreach (step_results[i]) pending_results = {pending_results, step_results[i]};
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    // Check one emitted result against the oldest expectation
    function void check_result(mld_pkg::result_t act);
      mld_pkg::result_t want;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual kind %0d byte %0h",
                 $time, act.kind, act.payload_byte);
        return;
      end
      want = pending_results.pop_front();
      compare_field("kind", 64'(want.kind), 64'(act.kind));
      compare_field("payload_byte", 64'(want.payload_byte), 64'(act.payload_byte));
      compare_field("end_of_packet", 64'(want.end_of_packet), 64'(act.end_of_packet));
      compare_field("dropped_bytes", 64'(want.dropped_bytes), 64'(act.dropped_bytes));
      compare_field("next_length", want.next_length, act.next_length);
      compare_field("last", 64'(want.last), 64'(act.last));
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  kind_o;
  logic [7:0]  payload_byte_o;
  logic        end_of_packet_o;
  logic [31:0] dropped_bytes_o;
  logic [63:0] next_length_o;
  logic        last_o;

  deframe_scoreboard sb = new();
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned bytes_sent = 0;
  logic        hold_trigger = 1'b0;
  logic        hold_seen = 1'b0;
  int unsigned hold_left = 0;

  marker_length_deframer DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .data_byte_i     (data_byte_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .kind_o          (kind_o),
    .payload_byte_o  (payload_byte_o),
    .end_of_packet_o (end_of_packet_o),
    .dropped_bytes_o (dropped_bytes_o),
    .next_length_o   (next_length_o),
    .last_o          (last_o)
  );

  // Generate the clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Drive the receiver: stall at random, or hold off for a long stretch when triggered
  always @(posedge clk_i) begin
    if (hold_trigger != hold_seen) begin
      hold_seen   <= hold_trigger;
      hold_left   <= HoldOffCycles;
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Note accepted bytes first, then check emitted results
  always @(posedge clk_i) begin
    mld_pkg::result_t act;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_byte(data_byte_i);
      if (out_valid_o && out_ready_i) begin
        act.kind          = mld_pkg::kind_e'(kind_o);
        act.payload_byte  = payload_byte_o;
        act.end_of_packet = end_of_packet_o;
        act.dropped_bytes = dropped_bytes_o;
        act.next_length   = next_length_o;
        act.last          = last_o;
        sb.check_result(act);
      end
    end
  end

  // Abort a run that hangs
  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // Offer one byte, idling first at random, and hold it until the transaction completes
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    bytes_sent++;
  endtask

  // Send junk that never forms a marker and never ends on a marker byte
  task automatic send_garbage(input int unsigned n);
    int unsigned run;
    logic [7:0]  b;
    run = 0;
    for (int unsigned i = 0; i < n; i++) begin
      if (i + 1 < n && run < mld_pkg::MarkerLen - 1 && $urandom_range(2) == 0)
        b = mld_pkg::MarkerByte;
      else b = 8'($urandom_range(254));
      run = (b == mld_pkg::MarkerByte) ? run + 1 : 0;
      send_byte(b);
    end
  endtask

  // Send optional junk, the marker, the big-endian length and the payload
  task automatic send_frame(input int unsigned junk, input logic [63:0] frame_len);
    send_garbage(junk);
    repeat (mld_pkg::MarkerLen) send_byte(mld_pkg::MarkerByte);
    for (int i = mld_pkg::LenBytes - 1; i >= 0; i--) send_byte(frame_len[i*8 +: 8]);
    for (longint unsigned i = 0; i < frame_len; i++) send_byte(8'($urandom_range(255)));
  endtask

  // Set the idling pattern for the part of the run reached so far
  task automatic pick_idling();
    if (bytes_sent < RandomBytes / 4) begin
      send_idle_pct  = 0;
      recv_stall_pct = 0;
    end else if (bytes_sent < RandomBytes / 2) begin
      send_idle_pct  = 76;
      recv_stall_pct = 0;
    end else if (bytes_sent < 3 * RandomBytes / 4) begin
      send_idle_pct  = 0;
      recv_stall_pct = 76;
    end else begin
      send_idle_pct  = 10;
      recv_stall_pct = 10;
    end
  endtask

  initial begin
    logic [63:0] frame_len;
    int unsigned junk;
    int unsigned pick;
    logic        hold_fired;
    hold_fired = 1'b0;

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: lone drop, broken run, zero length after drops, one-byte payload
    send_byte(8'h00);
    send_byte(mld_pkg::MarkerByte);
    send_byte(mld_pkg::MarkerByte);
    send_byte(8'h00);
    send_frame(0, 64'd0);
    send_frame(0, 64'd1);

    // Random frames, mostly small, with junk in between now and then
    while (bytes_sent < RandomBytes) begin
      pick_idling();
      if (!hold_fired && bytes_sent >= 120) begin
        hold_trigger <= ~hold_trigger;
        hold_fired = 1'b1;
      end
      junk = ($urandom_range(2) == 0) ? $urandom_range(1, 6) : 0;
      pick = $urandom_range(39);
      if (pick == 0) frame_len = 64'(256 + $urandom_range(44));
      else if (pick <= 6) frame_len = 64'd0;
      else frame_len = 64'($urandom_range(1, 24));
      send_frame(junk, frame_len);
    end

    // Finish on a fifth marker byte, which starts a huge length; its payload is left open at the end
    send_garbage(3);
    repeat (mld_pkg::MarkerLen + 1) send_byte(mld_pkg::MarkerByte);
    repeat (mld_pkg::LenBytes - 1) send_byte(8'($urandom_range(255)));
    repeat (6) send_byte(8'($urandom_range(255)));
    in_valid_i <= 1'b0;

    // Drain the result queue, then watch for strays
    recv_stall_pct = 0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (sb.pending() != 0) begin
      sb.errors++;
      $display("%0t: results still due: expected 0, actual %0d", $time, sb.pending());
    end

    if (sb.errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/mld_pkg.sv
rtl/core/marker_length_deframer.sv
verif/tb_marker_length_deframer.sv
